/* sv/mfs_pkg.sv */
// ----------------------------------------------------------------------------
// mfs_pkg
// Shared types and constants of the multilevel feedback scheduler: operation
// codes, stream field layout and the controller/datapath command bundle.
// ----------------------------------------------------------------------------
package mfs_pkg;

    // Operation codes carried in the slave-side tuser
    typedef enum logic [1:0] {
        MODE_NEW     = 2'd0,
        MODE_REQUEUE = 2'd1,
        MODE_SELECT  = 2'd2,
        MODE_CHECK   = 2'd3
    } t_mode;

    // Field widths
    localparam int MODE_W  = 2;
    localparam int PID_W   = 8;
    localparam int TIME_W  = 16;
    localparam int LEVEL_W = 3;
    localparam int WAIT_W  = 7;

    // Slave-side tdata layout, lowest bit first
    localparam int PID_LSB     = 0;
    localparam int ELAPSED_LSB = PID_LSB + PID_W;
    localparam int DONE_LSB    = ELAPSED_LSB + TIME_W;
    localparam int SERVICE_LSB = DONE_LSB + TIME_W;
    localparam int IN_DATA_W   = SERVICE_LSB + TIME_W;

    // Master-side tdata: found, id, level, keep, waiting, error, zero pad
    localparam int OUT_USED_W = 1 + PID_W + LEVEL_W + 1 + WAIT_W + 1;
    localparam int OUT_DATA_W = 24;
    localparam int OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;    // latch the accepted transaction
        logic exec;       // apply the operation to the queue state
        logic load_now;   // load the result register from this cycle's logic
        logic load_read;  // load the result register with the popped id
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_select;  // latched operation pops a level
    } t_dp_status;

endpackage

/* sv/multilevel_feedback_scheduler.sv */
// ----------------------------------------------------------------------------
// multilevel_feedback_scheduler
// Multilevel feedback queue scheduler with LAST_LEVEL+1 FIFO levels of ids.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side: one transaction per operation. tuser carries the mode
//   (new arrival, requeue preempted, select next, run check); tdata carries
//   process id, elapsed, done and service times.
//   Master side: exactly one result transaction per operation, with found,
//   selected id and level, keep-running, waiting count and push error.
//   Result path: an accepted operation is executed, then its result is
//   registered and held; a select first passes a load state, which is the
//   registered read of the id store. Throughput: one operation at a time.
//   The slave side stays not ready until the result has been taken.
//   Reset clears all level pointers and counts, the waiting total and the
//   recorded level; the id store is not cleared and needs no sweep.
//   A stall on the master side holds the result and its data stable.
// ----------------------------------------------------------------------------
module multilevel_feedback_scheduler #(
    parameter int LAST_LEVEL  = 3,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // mode
    input  logic [mfs_pkg::MODE_W-1:0]         i_s_axis_tuser,
    // process_id, elapsed_time, done_time, service_time
    input  logic [mfs_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // found, selected_id, selected_level, keep_running, waiting_count,
    // push_error, zero pad
    output logic [mfs_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata
);

    mfs_pkg::t_dp_cmd    cmd;
    mfs_pkg::t_dp_status status;

    // Sequencer
    mfs_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .i_status  (status),
        .o_s_ready (o_s_axis_tready),
        .o_m_valid (o_m_axis_tvalid),
        .o_cmd     (cmd)
    );

    // Queue state and result
    mfs_dpath #(
        .LAST_LEVEL  (LAST_LEVEL),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_status (status),
        .i_mode   (i_s_axis_tuser),
        .i_data   (i_s_axis_tdata),
        .o_data   (o_m_axis_tdata)
    );

endmodule

/* sv/mfs_ram.sv */
// ----------------------------------------------------------------------------
// mfs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/mfs_ctrl.sv */
// ----------------------------------------------------------------------------
// mfs_ctrl
// Sequencer of the scheduler: accept one transaction, execute it, fetch the
// popped id when selecting, then hold the result until it is taken.
// ----------------------------------------------------------------------------
module mfs_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_valid,
    input  logic                i_m_ready,
    input  mfs_pkg::t_dp_status i_status,
    output logic                o_s_ready,
    output logic                o_m_valid,
    output mfs_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_LOAD = 4'b0100,
        S_HOLD = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_status.is_select) begin
                    n_state = S_LOAD;
                end else begin
                    o_cmd.load_now = 1'b1;
                    n_state        = S_HOLD;
                end
            end
            S_LOAD: begin
                o_cmd.load_read = 1'b1;
                n_state         = S_HOLD;
            end
            S_HOLD: begin
                if (i_m_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_ready = (r_state == S_IDLE);
    assign o_m_valid = (r_state == S_HOLD);

endmodule

/* sv/mfs_dpath.sv */
// ----------------------------------------------------------------------------
// mfs_dpath
// Queue state of the scheduler: per-level ring pointers and counts, the id
// store, the recorded level, the run check and the result register.
// ----------------------------------------------------------------------------
module mfs_dpath #(
    parameter int LAST_LEVEL  = 3,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  mfs_pkg::t_dp_cmd                 i_cmd,
    output mfs_pkg::t_dp_status              o_status,
    input  logic [mfs_pkg::MODE_W-1:0]       i_mode,
    input  logic [mfs_pkg::IN_DATA_W-1:0]    i_data,
    output logic [mfs_pkg::OUT_DATA_W-1:0]   o_data
);

    localparam int NL  = LAST_LEVEL + 1;
    localparam int LVW = $clog2(NL);
    localparam int PW  = $clog2(QUEUE_DEPTH);
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int AW  = $clog2(NL * QUEUE_DEPTH);
    localparam int PIDW = mfs_pkg::PID_W;
    localparam int TW   = mfs_pkg::TIME_W;
    localparam int WW   = mfs_pkg::WAIT_W;
    localparam logic [LVW-1:0] LastLvl = LVW'(LAST_LEVEL);
    localparam logic [CW-1:0]  FullCnt = CW'(QUEUE_DEPTH);

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        logic [PW-1:0] q;
        q = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
        return q;
    endfunction

    // Latched transaction
    mfs_pkg::t_mode             r_mode;
    logic [mfs_pkg::IN_DATA_W-1:0] r_data;

    // Queue state
    logic [PW-1:0]  r_head  [NL];
    logic [PW-1:0]  r_tail  [NL];
    logic [CW-1:0]  r_count [NL];
    logic [WW-1:0]  r_total;
    logic [LVW-1:0] r_cur;
    logic           r_lvl_valid;

    // Pending select result waiting for the store read
    logic           r_pend_found;
    logic [LVW-1:0] r_pend_level;

    // Result register
    logic                         r_out_found;
    logic [PIDW-1:0]              r_out_id;
    logic [mfs_pkg::LEVEL_W-1:0]  r_out_level;
    logic                         r_out_keep;
    logic [WW-1:0]                r_out_wait;
    logic                         r_out_err;

    logic [PIDW-1:0] pid;
    logic [TW-1:0]   elapsed;
    logic [TW-1:0]   done_t;
    logic [TW-1:0]   service;
    logic            is_push;
    logic            is_select;
    logic [LVW-1:0]  tgt;
    logic            push_err;
    logic            push_ok;
    logic            sel_hit;
    logic [LVW-1:0]  sel_lvl;
    logic [TW:0]     finish_sum;
    logic            finished;
    logic [LVW-1:0]  chk_lvl;
    logic [TW:0]     threshold;
    logic            keep;
    logic [WW-1:0]   n_total;
    logic [AW-1:0]   waddr;
    logic [AW-1:0]   raddr;
    logic [PIDW-1:0] rdata;

    // Unpack the latched fields
    assign pid     = r_data[mfs_pkg::PID_LSB     +: PIDW];
    assign elapsed = r_data[mfs_pkg::ELAPSED_LSB +: TW];
    assign done_t  = r_data[mfs_pkg::DONE_LSB    +: TW];
    assign service = r_data[mfs_pkg::SERVICE_LSB +: TW];

    assign is_push   = (r_mode == mfs_pkg::MODE_NEW) || (r_mode == mfs_pkg::MODE_REQUEUE);
    assign is_select = (r_mode == mfs_pkg::MODE_SELECT);
    assign o_status.is_select = is_select;

    // Push target: level 0 for arrivals, one level down for requeues, staying at the last level
    always_comb begin
        if (r_mode == mfs_pkg::MODE_NEW) begin
            tgt = '0;
        end else if (r_cur == LastLvl) begin
            tgt = LastLvl;
        end else begin
            tgt = r_cur + 1'b1;
        end
    end

    assign push_err = ((r_mode == mfs_pkg::MODE_REQUEUE) && !r_lvl_valid)
                      || (r_count[tgt] == FullCnt);
    assign push_ok  = is_push && !push_err;

    // Priority encode: lowest non-empty level wins
    always_comb begin
        sel_hit = 1'b0;
        sel_lvl = '0;
        for (int l = NL - 1; l >= 0; l--) begin
            if (r_count[l] != '0) begin
                sel_hit = 1'b1;
                sel_lvl = LVW'(l);
            end
        end
    end

    // Run check: keep running if not finished and at the last level or within the level's quantum
    assign finish_sum = {1'b0, done_t} + {1'b0, elapsed};
    assign finished   = (finish_sum == {1'b0, service});
    assign chk_lvl    = r_lvl_valid ? r_cur : '0;
    assign threshold  = (TW + 1)'(1) << chk_lvl;
    assign keep       = !finished && ((chk_lvl == LastLvl) || ({1'b0, elapsed} < threshold));

    // Waiting total after this operation
    always_comb begin
        n_total = r_total;
        if (push_ok) begin
            n_total = r_total + 1'b1;
        end else if (is_select && sel_hit) begin
            n_total = r_total - 1'b1;
        end
    end

    // Store addresses: level base plus ring pointer
    assign waddr = AW'(AW'(tgt) * AW'(QUEUE_DEPTH)) + AW'(r_tail[tgt]);
    assign raddr = AW'(AW'(sel_lvl) * AW'(QUEUE_DEPTH)) + AW'(r_head[sel_lvl]);

    mfs_ram #(
        .WIDTH (PIDW),
        .DEPTH (NL * QUEUE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.exec && push_ok),
        .i_waddr (waddr),
        .i_wdata (pid),
        .i_re    (i_cmd.exec && is_select && sel_hit),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Latch the accepted transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= mfs_pkg::t_mode'(i_mode);
            r_data <= i_data;
        end
    end

    // Update pointers, counts and the recorded level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < NL; l++) begin
                r_head[l]  <= '0;
                r_tail[l]  <= '0;
                r_count[l] <= '0;
            end
            r_total     <= '0;
            r_cur       <= '0;
            r_lvl_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_total <= n_total;
            if (push_ok) begin
                r_tail[tgt]  <= bump(r_tail[tgt]);
                r_count[tgt] <= r_count[tgt] + 1'b1;
            end else if (is_select && sel_hit) begin
                r_head[sel_lvl]  <= bump(r_head[sel_lvl]);
                r_count[sel_lvl] <= r_count[sel_lvl] - 1'b1;
                r_cur            <= sel_lvl;
                r_lvl_valid      <= 1'b1;
            end
        end
    end

    // Hold the select outcome until the id comes out of the store
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_pend_found <= is_select && sel_hit;
            r_pend_level <= sel_lvl;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_now) begin
            r_out_found <= 1'b0;
            r_out_id    <= '0;
            r_out_level <= '0;
            r_out_keep  <= (r_mode == mfs_pkg::MODE_CHECK) && keep;
            r_out_wait  <= n_total;
            r_out_err   <= is_push && push_err;
        end else if (i_cmd.load_read) begin
            r_out_found <= r_pend_found;
            r_out_id    <= r_pend_found ? rdata : '0;
            r_out_level <= r_pend_found ? mfs_pkg::LEVEL_W'(r_pend_level) : '0;
            r_out_keep  <= 1'b0;
            r_out_wait  <= r_total;
            r_out_err   <= 1'b0;
        end
    end

    assign o_data = {{mfs_pkg::OUT_PAD_W{1'b0}}, r_out_err, r_out_wait, r_out_keep,
                     r_out_level, r_out_id, r_out_found};

endmodule

/* sv/mfs_checker.sv */
// ----------------------------------------------------------------------------
// mfs_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module mfs_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_s_axis_tvalid,
    input logic                               o_s_axis_tready,
    input logic [mfs_pkg::MODE_W-1:0]         i_s_axis_tuser,
    input logic [mfs_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    input logic                               o_m_axis_tvalid,
    input logic                               i_m_axis_tready,
    input logic [mfs_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata
);

    // Never take a new transaction while a result is pending
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && o_m_axis_tvalid))
        else $error("input ready while a result is pending");

    // Drop ready right after a transaction is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input ready again right after acceptance");

    // Hold a stalled result
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("stalled result changed");

    // No id or level without a found process
    a_empty_select: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tdata[0]) |-> (o_m_axis_tdata[11:1] == '0))
        else $error("id or level reported without a found process");

    // A select and a push error never come together
    a_found_vs_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tdata[0] && o_m_axis_tdata[20]))
        else $error("found and push error both set");

endmodule

bind multilevel_feedback_scheduler mfs_checker u_mfs_checker (.*);

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Stream-level test of the multilevel feedback scheduler. A queue of
// operations (arrivals, requeues, selects and run checks) feeds a bursty
// driver. Each accepted transaction runs through a scheduler model kept here,
// and the monitor checks every result field against the oldest prediction.
// The receiver stalls on its own pattern and once holds off for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LAST_LEVEL  = 3;
    localparam int QUEUE_DEPTH = 16;
    localparam int NUM_LEVELS  = LAST_LEVEL + 1;
    localparam int RANDOM_OPS  = 750;
    localparam int HOLD_START  = 2000;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_WAIT  = 10;

    // Field widths taken from the shared package
    localparam int MODE_W     = mfs_pkg::MODE_W;
    localparam int PID_W      = mfs_pkg::PID_W;
    localparam int TIME_W     = mfs_pkg::TIME_W;
    localparam int LEVEL_W    = mfs_pkg::LEVEL_W;
    localparam int WAIT_W     = mfs_pkg::WAIT_W;
    localparam int IN_DATA_W  = mfs_pkg::IN_DATA_W;
    localparam int OUT_DATA_W = mfs_pkg::OUT_DATA_W;

    typedef struct {
        mfs_pkg::t_mode    mode;
        logic [PID_W-1:0]  pid;
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] done;
        logic [TIME_W-1:0] service;
    } t_sched_op;

    typedef struct {
        logic               found;
        logic [PID_W-1:0]   sel_id;
        logic [LEVEL_W-1:0] sel_level;
        logic               keep;
        logic [WAIT_W-1:0]  waiting;
        logic               push_err;
    } t_sched_result;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [MODE_W-1:0]     s_tuser = '0;     // mode
    logic [IN_DATA_W-1:0]  s_tdata = '0;     // pid, elapsed, done, service
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;          // found, id, level, keep, waiting, error, pad

    multilevel_feedback_scheduler #(
        .LAST_LEVEL  (LAST_LEVEL),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stimulus and expected results
    t_sched_op     pending_ops[$];
    t_sched_result expected_results[$];
    t_sched_op     in_flight;
    int            n_ops_total = 0;
    int            n_accepted = 0;
    int            n_fail = 0;

    // Run statistics
    int            n_mode[4] = '{0, 0, 0, 0};
    int            n_dropped = 0;
    int            n_found = 0;
    int            n_kept = 0;
    int            max_waiting = 0;

    // Scheduler state mirrored from the accepted transactions
    logic [PID_W-1:0] lvl_ids [NUM_LEVELS][QUEUE_DEPTH];
    int unsigned      lvl_head [NUM_LEVELS] = '{default: 0};
    int unsigned      lvl_tail [NUM_LEVELS] = '{default: 0};
    int unsigned      lvl_fill [NUM_LEVELS] = '{default: 0};
    int unsigned      waiting_total = 0;
    int unsigned      run_level = 0;
    bit               run_level_known = 1'b0;

    // Append a process id to a level; return 1 when the level is full
    function automatic bit enqueue_id(int unsigned lvl, logic [PID_W-1:0] id);
        if (lvl_fill[lvl] >= QUEUE_DEPTH) return 1'b1;
        lvl_ids[lvl][lvl_tail[lvl]] = id;
        lvl_tail[lvl] = (lvl_tail[lvl] + 1) % QUEUE_DEPTH;
        lvl_fill[lvl]++;
        waiting_total++;
        return 1'b0;
    endfunction

    // Apply one operation to the scheduler state and form its result
    task automatic schedule_op(input t_sched_op op, output t_sched_result res);
        int unsigned      target;
        int unsigned      lvl;
        logic [TIME_W:0]  finish_sum;
        res = '{found: 1'b0, sel_id: '0, sel_level: '0, keep: 1'b0,
                waiting: '0, push_err: 1'b0};
        case (op.mode)
            mfs_pkg::MODE_NEW: begin
                res.push_err = enqueue_id(0, op.pid);
            end
            mfs_pkg::MODE_REQUEUE: begin
                if (!run_level_known) begin
                    res.push_err = 1'b1;
                end else begin
                    target = (run_level < LAST_LEVEL) ? run_level + 1 : LAST_LEVEL;
                    res.push_err = enqueue_id(target, op.pid);
                end
            end
            mfs_pkg::MODE_SELECT: begin
                // pop the head of the lowest-numbered non-empty level
                for (int l = 0; l < NUM_LEVELS; l++) begin
                    if (!res.found && lvl_fill[l] != 0) begin
                        res.found     = 1'b1;
                        res.sel_id    = lvl_ids[l][lvl_head[l]];
                        res.sel_level = LEVEL_W'(l);
                        lvl_head[l]   = (lvl_head[l] + 1) % QUEUE_DEPTH;
                        lvl_fill[l]--;
                        waiting_total--;
                        run_level       = l;
                        run_level_known = 1'b1;
                    end
                end
            end
            default: begin
                // finished, else last level keeps running, else quantum 2^level
                lvl = run_level_known ? run_level : 0;
                finish_sum = {1'b0, op.done} + {1'b0, op.elapsed};
                if (finish_sum == {1'b0, op.service})
                    res.keep = 1'b0;
                else if (lvl == LAST_LEVEL)
                    res.keep = 1'b1;
                else
                    res.keep = ({1'b0, op.elapsed} < (17'd1 << lvl));
            end
        endcase
        res.waiting = waiting_total[WAIT_W-1:0];
    endtask

    // Queue one operation; fields are cut to their widths here
    function automatic void add_op(mfs_pkg::t_mode m, int unsigned pid,
                                   int unsigned e, int unsigned d, int unsigned s);
        t_sched_op op;
        op = '{mode: m, pid: PID_W'(pid), elapsed: TIME_W'(e), done: TIME_W'(d),
               service: TIME_W'(s)};
        pending_ops.insert(pending_ops.size(), op);
        n_ops_total++;
    endfunction

    // Run-check times: finishing, near the quantum, fully random or extremes
    task automatic random_times(output int unsigned e, output int unsigned d,
                                output int unsigned s);
        case ($urandom_range(0, 3))
            0: begin
                e = $urandom_range(0, 40);
                d = $urandom_range(0, 65535 - e);
                if (d + e == 0) e = 1;
                s = d + e;
            end
            1: begin
                e = $urandom_range(0, 9);
                d = $urandom_range(0, 65535);
                s = $urandom_range(1, 65535);
            end
            2: begin
                e = $urandom_range(0, 65535);
                d = $urandom_range(0, 65535);
                s = $urandom_range(1, 65535);
            end
            default: begin
                e = $urandom_range(0, 1) ? 32'hFFFF : 32'h0000;
                d = $urandom_range(0, 1) ? 32'hFFFF : 32'h0000;
                s = $urandom_range(0, 1) ? 32'hFFFF : 32'h0001;
            end
        endcase
    endtask

    // Compare one result field; count and report a mismatch
    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            n_fail++;
        end
    endfunction

    // Drive operations in bursts with random gaps; predict on acceptance
    always @(posedge clk) begin : drive_proc
        t_sched_op     next_op;
        t_sched_result res;
        int            gap_left;
        int            burst_left;
        if (!rst_n) begin
            s_tvalid   <= 1'b0;
            gap_left   = 0;
            burst_left = 1;
        end else begin
            if (s_tvalid && s_tready) begin
                schedule_op(in_flight, res);
                expected_results.insert(expected_results.size(), res);
                n_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_ops.size() != 0) begin
                    next_op = pending_ops.pop_front();
                    in_flight <= next_op;
                    s_tuser   <= next_op.mode;
                    s_tdata   <= {next_op.service, next_op.done, next_op.elapsed, next_op.pid};
                    s_tvalid  <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 15);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall pattern, with one long hold-off in mid-run
    always @(posedge clk) begin : ready_proc
        int rx_cycle;
        int hold_left;
        if (!rst_n) begin
            m_tready  <= 1'b0;
            rx_cycle  = 0;
            hold_left = 0;
        end else begin
            rx_cycle++;
            if (rx_cycle == HOLD_START) begin
                hold_left = LONG_HOLD;
                m_tready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case ((rx_cycle / 64) % 4)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 1) == 0);
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    // Check each result transaction against the oldest prediction
    always @(posedge clk) begin : monitor_proc
        t_sched_result want;
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("result transaction with no operation outstanding: %h", m_tdata);
                n_fail++;
            end else begin
                want = expected_results.pop_front();
                check_field("found", 32'(want.found), 32'(m_tdata[0]));
                check_field("selected_id", 32'(want.sel_id), 32'(m_tdata[8:1]));
                check_field("selected_level", 32'(want.sel_level), 32'(m_tdata[11:9]));
                check_field("keep_running", 32'(want.keep), 32'(m_tdata[12]));
                check_field("waiting_count", 32'(want.waiting), 32'(m_tdata[19:13]));
                check_field("push_error", 32'(want.push_err), 32'(m_tdata[20]));
                check_field("pad", 32'd0, 32'(m_tdata[OUT_DATA_W-1:21]));
                n_dropped += int'(want.push_err);
                n_found   += int'(want.found);
                n_kept    += int'(want.keep);
                if (int'(want.waiting) > max_waiting) max_waiting = int'(want.waiting);
            end
        end
    end

    initial begin : main_proc
        int unsigned       e, d, s;
        int                n;
        int                directed;

        // Directed: error paths before any select, then one id walked down all levels
        add_op(mfs_pkg::MODE_REQUEUE, 8'hFF, 0, 0, 0);
        add_op(mfs_pkg::MODE_CHECK, 8'h00, 16'h0000, 16'h0000, 16'h0001);
        add_op(mfs_pkg::MODE_CHECK, 8'h00, 16'h0001, 16'h0000, 16'hFFFF);
        add_op(mfs_pkg::MODE_CHECK, 8'h00, 16'h0000, 16'hFFFF, 16'hFFFF);
        add_op(mfs_pkg::MODE_SELECT, 8'h00, 0, 0, 0);
        add_op(mfs_pkg::MODE_NEW, 8'h00, 0, 0, 0);
        add_op(mfs_pkg::MODE_NEW, 8'hFF, 0, 0, 0);
        add_op(mfs_pkg::MODE_NEW, 8'hA5, 0, 0, 0);
        add_op(mfs_pkg::MODE_NEW, 8'h5A, 0, 0, 0);
        add_op(mfs_pkg::MODE_SELECT, 8'h00, 0, 0, 0);
        add_op(mfs_pkg::MODE_REQUEUE, 8'h00, 0, 0, 0);
        repeat (4) add_op(mfs_pkg::MODE_SELECT, 8'h00, 0, 0, 0);
        add_op(mfs_pkg::MODE_CHECK, 8'h00, 16'h0001, 16'h0000, 16'h0100);
        add_op(mfs_pkg::MODE_CHECK, 8'h00, 16'h0002, 16'h0000, 16'h0100);
        add_op(mfs_pkg::MODE_REQUEUE, 8'h00, 0, 0, 0);
        add_op(mfs_pkg::MODE_SELECT, 8'h00, 0, 0, 0);
        add_op(mfs_pkg::MODE_REQUEUE, 8'h00, 0, 0, 0);
        add_op(mfs_pkg::MODE_SELECT, 8'h00, 0, 0, 0);
        // sum wraps to service only at 16 bits: must keep running at the last level
        add_op(mfs_pkg::MODE_CHECK, 8'h00, 16'h0002, 16'hFFFF, 16'h0001);
        add_op(mfs_pkg::MODE_CHECK, 8'h00, 16'hFFFF, 16'h0000, 16'hFFFF);
        add_op(mfs_pkg::MODE_REQUEUE, 8'h00, 0, 0, 0);
        add_op(mfs_pkg::MODE_SELECT, 8'h00, 0, 0, 0);
        add_op(mfs_pkg::MODE_SELECT, 8'h00, 0, 0, 0);
        add_op(mfs_pkg::MODE_REQUEUE, 8'h81, 0, 0, 0);
        directed = n_ops_total;

        // Random: mostly scheduling rounds, plus fill bursts, drains and noise
        while (n_ops_total < directed + RANDOM_OPS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    n = $urandom_range(0, 2);
                    repeat (n) add_op(mfs_pkg::MODE_NEW, $urandom, $urandom, $urandom,
                                      $urandom);
                    add_op(mfs_pkg::MODE_SELECT, $urandom, $urandom, $urandom, $urandom);
                    n = $urandom_range(1, 3);
                    repeat (n) begin
                        random_times(e, d, s);
                        add_op(mfs_pkg::MODE_CHECK, $urandom, e, d, s);
                    end
                    if ($urandom_range(0, 2) != 0)
                        add_op(mfs_pkg::MODE_REQUEUE, $urandom, $urandom, $urandom,
                               $urandom);
                end
                5, 6: begin
                    // push a run that can overflow the target level
                    n = $urandom_range(8, 20);
                    if ($urandom_range(0, 1) != 0)
                        repeat (n) add_op(mfs_pkg::MODE_NEW, $urandom, $urandom, $urandom,
                                          $urandom);
                    else
                        repeat (n) add_op(mfs_pkg::MODE_REQUEUE, $urandom, $urandom,
                                          $urandom, $urandom);
                end
                7: begin
                    n = $urandom_range(5, 20);
                    repeat (n) add_op(mfs_pkg::MODE_SELECT, $urandom, $urandom, $urandom,
                                      $urandom);
                end
                default: begin
                    n = $urandom_range(1, 8);
                    repeat (n) add_op(mfs_pkg::t_mode'($urandom_range(0, 3)), $urandom,
                                      $urandom, $urandom, $urandom_range(1, 65535));
                end
            endcase
        end
        foreach (pending_ops[i]) n_mode[pending_ops[i].mode]++;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every operation to be taken and every result to arrive
        while (n_accepted < n_ops_total) @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Covered %0d operations: %0d arrivals, %0d requeues, %0d selects, %0d checks",
                 n_ops_total, n_mode[mfs_pkg::MODE_NEW], n_mode[mfs_pkg::MODE_REQUEUE],
                 n_mode[mfs_pkg::MODE_SELECT], n_mode[mfs_pkg::MODE_CHECK]);
        $display("Dropped pushes %0d, selects that found a process %0d, checks kept %0d, peak waiting %0d",
                 n_dropped, n_found, n_kept, max_waiting);
        if (n_fail == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run
    initial begin : watchdog_proc
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

/* files.f */
sv/mfs_pkg.sv
sv/mfs_ram.sv
sv/mfs_ctrl.sv
sv/mfs_dpath.sv
sv/multilevel_feedback_scheduler.sv
sv/mfs_checker.sv
sim/testbench.sv
